// ===== sv/tvsm_pkg.sv =====
package tvsm_pkg;

    // Sample memory geometry
    localparam int VOICE_DEPTH = 4096;
    localparam int NUM_VOICES  = 3;
    localparam int ADDR_W      = $clog2(VOICE_DEPTH);
    localparam int POS_W       = ADDR_W + 1;
    localparam int LEN_W       = 13;
    localparam int CMP_W       = (POS_W > LEN_W) ? POS_W : LEN_W;
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = SAMPLE_W + 2;
    localparam int GAP_W       = 16;
    localparam int TIME_W      = 32;
    localparam int LOAD_ADDR_W = 12;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;

    // Reset position: every voice idle
    localparam logic [CMP_W-1:0] IDLE_POS = CMP_W'(4096);

    localparam logic [LEN_W-1:0] MOVE_LEN_RST   = LEN_W'(1680);
    localparam logic [LEN_W-1:0] ACCEPT_LEN_RST = LEN_W'(3840);
    localparam logic [LEN_W-1:0] BACK_LEN_RST   = LEN_W'(3360);
    localparam logic [GAP_W-1:0] MOVE_GAP_RST   = GAP_W'(80);

    localparam logic signed [SUM_W-1:0] SAT_HIGH = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LOW  = -SUM_W'(32768);

    localparam int STATUS_W = 3;

    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_PLAY = 2'd1,
        FUNC_LOAD = 2'd2,
        FUNC_NOP  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        VOICE_MOVE    = 2'd0,
        VOICE_ACCEPT  = 2'd1,
        VOICE_BACK    = 2'd2,
        VOICE_INVALID = 2'd3
    } t_voice;

    typedef enum logic [STATUS_W-1:0] {
        ST_NOT_PLAY  = 3'd0,
        ST_STARTED   = 3'd1,
        ST_INVALID   = 3'd2,
        ST_THROTTLED = 3'd3,
        ST_BLOCKED   = 3'd4,
        ST_PLAYING   = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOVE_LEN   = 2'd0,
        CFG_ACCEPT_LEN = 2'd1,
        CFG_BACK_LEN   = 2'd2,
        CFG_MOVE_GAP   = 2'd3
    } t_cfg_idx;

    // Per-item read request from the voice controller to the mix stage
    typedef struct packed {
        logic                                mix_en;
        logic [NUM_VOICES-1:0]               mask;
        t_status                             status;
        logic [NUM_VOICES-1:0][ADDR_W-1:0]   rd_addr;
    } t_issue;

endpackage

// ===== sv/tvsm_ram.sv =====
module tvsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tvsm_ctrl.sv =====
module tvsm_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tvsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tvsm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_accept,
    input  tvsm_pkg::t_func                     i_func,
    input  tvsm_pkg::t_voice                    i_sound,
    input  logic [tvsm_pkg::TIME_W-1:0]         i_now_ms,
    output tvsm_pkg::t_issue                    o_issue
);

    localparam int NV = tvsm_pkg::NUM_VOICES;
    localparam int CW = tvsm_pkg::CMP_W;

    logic [NV-1:0][CW-1:0]                 r_pos, n_pos;
    logic [NV-1:0][tvsm_pkg::LEN_W-1:0]    r_len;
    logic [tvsm_pkg::GAP_W-1:0]            r_gap;
    logic [tvsm_pkg::TIME_W-1:0]           r_last, n_last;

    logic [NV-1:0][CW-1:0]                 eff_len;
    logic [NV-1:0]                         active;
    logic [tvsm_pkg::TIME_W-1:0]           since_last;
    logic                                  throttled;
    tvsm_pkg::t_status                     status;

    // Length clamped to the sample memory depth
    always_comb begin
        for (int v = 0; v < NV; v++) begin
            if (CW'(r_len[v]) > CW'(tvsm_pkg::VOICE_DEPTH)) begin
                eff_len[v] = CW'(tvsm_pkg::VOICE_DEPTH);
            end else begin
                eff_len[v] = CW'(r_len[v]);
            end
            active[v] = r_pos[v] < eff_len[v];
        end
    end

    assign since_last = i_now_ms - r_last;
    assign throttled  = (r_last != '0) &&
                        (since_last < tvsm_pkg::TIME_W'(r_gap));

    always_comb begin
        n_pos  = r_pos;
        n_last = r_last;
        status = tvsm_pkg::ST_NOT_PLAY;
        case (i_func)
            tvsm_pkg::FUNC_TICK: begin
                for (int v = 0; v < NV; v++) begin
                    if (active[v]) begin
                        n_pos[v] = r_pos[v] + CW'(1);
                    end
                end
            end
            tvsm_pkg::FUNC_PLAY: begin
                case (i_sound)
                    tvsm_pkg::VOICE_MOVE: begin
                        if (throttled) begin
                            status = tvsm_pkg::ST_THROTTLED;
                        end else begin
                            n_last = i_now_ms;
                            if (active[tvsm_pkg::VOICE_ACCEPT] ||
                                active[tvsm_pkg::VOICE_BACK]) begin
                                status = tvsm_pkg::ST_BLOCKED;
                            end else if (active[tvsm_pkg::VOICE_MOVE]) begin
                                status = tvsm_pkg::ST_PLAYING;
                            end else begin
                                status = tvsm_pkg::ST_STARTED;
                                n_pos[tvsm_pkg::VOICE_MOVE] = '0;
                            end
                        end
                    end
                    tvsm_pkg::VOICE_ACCEPT, tvsm_pkg::VOICE_BACK: begin
                        if (active[i_sound]) begin
                            status = tvsm_pkg::ST_PLAYING;
                        end else begin
                            status = tvsm_pkg::ST_STARTED;
                            n_pos[i_sound] = '0;
                        end
                    end
                    default: begin
                        status = tvsm_pkg::ST_INVALID;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_issue.mix_en = (i_func == tvsm_pkg::FUNC_TICK);
        o_issue.mask   = (i_func == tvsm_pkg::FUNC_TICK) ? active : '0;
        o_issue.status = status;
        for (int v = 0; v < NV; v++) begin
            o_issue.rd_addr[v] = r_pos[v][tvsm_pkg::ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < NV; v++) begin
                r_pos[v] <= tvsm_pkg::IDLE_POS;
            end
            r_last <= '0;
            r_len[tvsm_pkg::VOICE_MOVE]   <= tvsm_pkg::MOVE_LEN_RST;
            r_len[tvsm_pkg::VOICE_ACCEPT] <= tvsm_pkg::ACCEPT_LEN_RST;
            r_len[tvsm_pkg::VOICE_BACK]   <= tvsm_pkg::BACK_LEN_RST;
            r_gap <= tvsm_pkg::MOVE_GAP_RST;
        end else begin
            if (i_accept) begin
                r_pos  <= n_pos;
                r_last <= n_last;
            end
            if (i_cfg_we) begin
                case (tvsm_pkg::t_cfg_idx'(i_cfg_index))
                    tvsm_pkg::CFG_MOVE_LEN:
                        r_len[tvsm_pkg::VOICE_MOVE] <= i_cfg_data[tvsm_pkg::LEN_W-1:0];
                    tvsm_pkg::CFG_ACCEPT_LEN:
                        r_len[tvsm_pkg::VOICE_ACCEPT] <= i_cfg_data[tvsm_pkg::LEN_W-1:0];
                    tvsm_pkg::CFG_BACK_LEN:
                        r_len[tvsm_pkg::VOICE_BACK] <= i_cfg_data[tvsm_pkg::LEN_W-1:0];
                    tvsm_pkg::CFG_MOVE_GAP:
                        r_gap <= i_cfg_data[tvsm_pkg::GAP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ===== sv/tvsm_mix.sv =====
module tvsm_mix (
    input  logic                                                   i_clk,
    input  logic                                                   i_rst_n,
    input  logic                                                   i_accept,
    input  tvsm_pkg::t_issue                                       i_issue,
    input  logic [tvsm_pkg::NUM_VOICES-1:0][tvsm_pkg::SAMPLE_W-1:0] i_rdata,
    input  logic                                                   i_m_tready,
    output logic                                                   o_in_ready,
    output logic                                                   o_m_tvalid,
    output logic [tvsm_pkg::SAMPLE_W-1:0]                          o_mix,
    output tvsm_pkg::t_status                                      o_status
);

    localparam int NV = tvsm_pkg::NUM_VOICES;
    localparam int SW = tvsm_pkg::SUM_W;

    // Read-data stage: RAM words arrive here in the cycle after issue
    logic                          r_s1_valid;
    logic                          r_s1_mix_en;
    logic [NV-1:0]                 r_s1_mask;
    tvsm_pkg::t_status             r_s1_status;

    logic                          r_out_valid;
    logic [tvsm_pkg::SAMPLE_W-1:0] r_out_mix;
    tvsm_pkg::t_status             r_out_status;

    logic                          out_ready;
    logic                          s1_adv;
    logic signed [SW-1:0]          sum;
    logic [tvsm_pkg::SAMPLE_W-1:0] sat;

    assign out_ready  = !r_out_valid || i_m_tready;
    assign s1_adv     = r_s1_valid && out_ready;
    assign o_in_ready = !r_s1_valid || out_ready;

    always_comb begin
        sum = '0;
        for (int v = 0; v < NV; v++) begin
            if (r_s1_mask[v]) begin
                sum = sum + SW'($signed(i_rdata[v]));
            end
        end
        if (sum > tvsm_pkg::SAT_HIGH) begin
            sat = tvsm_pkg::SAT_HIGH[tvsm_pkg::SAMPLE_W-1:0];
        end else if (sum < tvsm_pkg::SAT_LOW) begin
            sat = tvsm_pkg::SAT_LOW[tvsm_pkg::SAMPLE_W-1:0];
        end else begin
            sat = sum[tvsm_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_mix_en <= i_issue.mix_en;
            r_s1_mask   <= i_issue.mask;
            r_s1_status <= i_issue.status;
        end
        if (s1_adv) begin
            r_out_mix    <= r_s1_mix_en ? sat : '0;
            r_out_status <= r_s1_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_mix      = r_out_mix;
    assign o_status   = r_out_status;

endmodule

// ===== sv/three_voice_sample_mixer.sv =====
// Three-voice sound-effect mixer (voice 0 move, 1 accept, 2 back). Every input
// beat yields exactly one output beat, in order, and a new beat is taken every
// cycle while the sink keeps tready high: the synchronous sample RAM read is
// registered in the read-data stage and the saturating add lands in the output
// register. Input tready drops only when both the read-data stage and the output
// register hold a beat and the sink refuses. Input tuser carries func (tick,
// play, load, nop) and the voice; tdata carries the play time and the load
// address and value. A tick adds the current sample of every playing voice and
// advances it; a play restarts a finished voice, with move requests rate
// limited by move_gap_ms and held off while accept or back plays. Samples live
// in three 4096 x 16 RAMs and are undefined until loaded; there is no clearing
// pass. Write the configuration registers only while the block is idle.
module three_voice_sample_mixer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [tvsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tvsm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [31:0] now_ms, [43:32] load_address, [59:44] load_value, [63:60] zero
    input  logic [63:0]                         i_s_axis_tdata,
    // [1:0] func, [3:2] sound
    input  logic [3:0]                          i_s_axis_tuser,
    // Output stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [15:0] mix_sample, [18:16] play_status, [23:19] zero
    output logic [23:0]                         o_m_axis_tdata
);

    localparam int NV = tvsm_pkg::NUM_VOICES;

    logic                                       accept;
    tvsm_pkg::t_func                            func;
    tvsm_pkg::t_voice                           sound;
    logic [tvsm_pkg::TIME_W-1:0]                now_ms;
    logic [tvsm_pkg::LOAD_ADDR_W-1:0]           load_address;
    logic [tvsm_pkg::SAMPLE_W-1:0]              load_value;
    tvsm_pkg::t_issue                           issue;
    logic [NV-1:0][tvsm_pkg::SAMPLE_W-1:0]      rdata;
    logic                                       in_ready;
    logic [tvsm_pkg::SAMPLE_W-1:0]              mix;
    tvsm_pkg::t_status                          status;

    // Unpack the input beat
    assign func         = tvsm_pkg::t_func'(i_s_axis_tuser[1:0]);
    assign sound        = tvsm_pkg::t_voice'(i_s_axis_tuser[3:2]);
    assign now_ms       = i_s_axis_tdata[31:0];
    assign load_address = i_s_axis_tdata[43:32];
    assign load_value   = i_s_axis_tdata[59:44];

    assign o_s_axis_tready = in_ready;
    assign accept          = i_s_axis_tvalid && in_ready;

    // Voice positions, lengths, move throttle and play decisions
    tvsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_func      (func),
        .i_sound     (sound),
        .i_now_ms    (now_ms),
        .o_issue     (issue)
    );

    // One sample RAM per voice: write on a load beat, read at the voice
    // position on every accepted beat so the read data holds while stalled.
    for (genvar v = 0; v < NV; v++) begin : g_voice
        logic we;
        assign we = accept && (func == tvsm_pkg::FUNC_LOAD) &&
                    (sound == tvsm_pkg::t_voice'(v)) &&
                    ({1'b0, load_address} < (tvsm_pkg::LOAD_ADDR_W+1)'(tvsm_pkg::VOICE_DEPTH));

        tvsm_ram #(
            .WIDTH (tvsm_pkg::SAMPLE_W),
            .DEPTH (tvsm_pkg::VOICE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (load_address[tvsm_pkg::ADDR_W-1:0]),
            .i_wdata (load_value),
            .i_re    (accept),
            .i_raddr (issue.rd_addr[v]),
            .o_rdata (rdata[v])
        );
    end

    // Sum, saturate and hold the result beat
    tvsm_mix u_mix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_issue    (issue),
        .i_rdata    (rdata),
        .i_m_tready (i_m_axis_tready),
        .o_in_ready (in_ready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_mix      (mix),
        .o_status   (status)
    );

    assign o_m_axis_tdata = {5'b0, status, mix};

endmodule
